// ===== src/modified_dh_link_transform_defines.svh =====
// ----------------------------------------------------------------------------
// modified_dh_link_transform_defines.svh
// Assertion macros used by the checker file of the link transform.
// ----------------------------------------------------------------------------
`ifndef MODIFIED_DH_LINK_TRANSFORM_DEFINES_SVH
`define MODIFIED_DH_LINK_TRANSFORM_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LDH_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LDH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ldh_pkg.sv =====
// ----------------------------------------------------------------------------
// ldh_pkg
// Types, constants and tables of the modified DH link transform.
// ----------------------------------------------------------------------------
package ldh_pkg;

  // Number of CORDIC rotations per angle (8 to 24).
  localparam int unsigned CORDIC_STEPS = 16;
  // Square root: one result bit per cycle over a 64-bit radicand.
  localparam int unsigned ROOT_STEPS   = 32;
  // Divider: 15 quotient bits, enough for a magnitude up to 16384.
  localparam int unsigned DIV_STEPS    = 15;

  // Shared iteration counter covers the longest loop.
  localparam int unsigned CNT_W = 5;
  localparam int unsigned ATAN_IDX_W = 5;

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // CORDIC datapath widths.
  localparam int unsigned XY_W   = 33;  // Q30 with headroom for the gain
  localparam int unsigned MAG_W  = 31;  // magnitude of a final x or y
  localparam int unsigned SQ_W   = 2 * MAG_W;
  localparam int unsigned RAD_W  = 64;
  localparam int unsigned RT_W   = 32;
  localparam int unsigned NUM_W  = 47;

  typedef logic signed [15:0] ang_in_t;
  typedef logic signed [31:0] ang_t;   // Q3.28
  typedef logic signed [23:0] len_t;
  typedef logic signed [15:0] rot_t;   // Q1.14

  localparam ang_t PI_Q28      = 32'sd843314857;
  localparam ang_t HALF_PI_Q28 = 32'sd421657428;

  localparam len_t LEN_MAX     = 24'sh7FFFFF;
  localparam len_t LEN_MIN     = 24'sh800000;
  localparam len_t ONE_Q14_LEN = 24'sd16384;

  typedef enum logic [1:0] {
    ROW_0,
    ROW_1,
    ROW_2,
    ROW_3
  } row_e;

  // Work item after angle reduction.
  typedef struct packed {
    ang_t z_alpha;
    logic neg_alpha;
    ang_t z_theta;
    logic neg_theta;
    len_t link_length;
    len_t link_offset;
  } work_t;

  // atan(2^-i) in Q28, rounded to nearest.
  function automatic ang_t atan_q28(input logic [ATAN_IDX_W-1:0] idx);
    ang_t v;
    case (idx)
      5'd0:    v = 32'sd210828714;
      5'd1:    v = 32'sd124459457;
      5'd2:    v = 32'sd65760959;
      5'd3:    v = 32'sd33381290;
      5'd4:    v = 32'sd16755422;
      5'd5:    v = 32'sd8385879;
      5'd6:    v = 32'sd4193963;
      5'd7:    v = 32'sd2097109;
      5'd8:    v = 32'sd1048571;
      5'd9:    v = 32'sd524287;
      5'd10:   v = 32'sd262144;
      5'd11:   v = 32'sd131072;
      5'd12:   v = 32'sd65536;
      5'd13:   v = 32'sd32768;
      5'd14:   v = 32'sd16384;
      5'd15:   v = 32'sd8192;
      5'd16:   v = 32'sd4096;
      5'd17:   v = 32'sd2048;
      5'd18:   v = 32'sd1024;
      5'd19:   v = 32'sd512;
      5'd20:   v = 32'sd256;
      5'd21:   v = 32'sd128;
      5'd22:   v = 32'sd64;
      5'd23:   v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/ldh_if.sv =====
// ----------------------------------------------------------------------------
// ldh_if
// Valid/ready channels of the link transform: link parameters in, rows out.
// ----------------------------------------------------------------------------
interface ldh_in_if;
  import ldh_pkg::*;

  logic    valid;
  logic    ready;
  ang_in_t twist_angle;
  len_t    link_length;
  ang_in_t joint_angle;
  len_t    link_offset;

  modport source (
    output valid, twist_angle, link_length, joint_angle, link_offset,
    input  ready
  );
  modport sink (
    input  valid, twist_angle, link_length, joint_angle, link_offset,
    output ready
  );
endinterface

interface ldh_out_if;
  import ldh_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] row_index;
  rot_t       col_zero;
  rot_t       col_one;
  rot_t       col_two;
  len_t       col_three;
  logic       last_row;

  modport source (
    output valid, row_index, col_zero, col_one, col_two, col_three, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_index, col_zero, col_one, col_two, col_three, last_row,
    output ready
  );
endinterface

// ===== src/modified_dh_link_transform.sv =====
// ----------------------------------------------------------------------------
// modified_dh_link_transform
// Modified Denavit-Hartenberg link transform: one link parameter word in,
// four matrix row words out, row 0 first, last_row set on row 3.
// ----------------------------------------------------------------------------
// The front reduces both angles into +-pi/2 and queues up to two words while
// the back is busy. In the back, the two sine/cosine lanes run side by side
// through CORDIC_STEPS rotations, a square root for gain removal and a
// divider, and that lane loop sets the sustained rate: the back takes no new
// word until the lanes have handed their results on. The four rows of a word
// leave through an output register one per cycle while the sink is ready,
// and the lanes meanwhile already work on the next word; the first row
// passes through the matrix register and then the output register.
// No clearing pass after reset.
module modified_dh_link_transform (
  input  logic      clk_i,
  input  logic      rst_ni,
  ldh_in_if.sink    in_i,
  ldh_out_if.source out_o
);
  import ldh_pkg::*;

  work_t front_data, back_data;
  logic  front_valid, front_ready, back_valid, back_ready;

  ldh_front u_front (
    .in_i          (in_i),
    .entry_o       (front_data),
    .entry_valid_o (front_valid),
    .entry_ready_i (front_ready)
  );

  ldh_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_data),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (back_data),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  ldh_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (back_data),
    .entry_valid_i (back_valid),
    .entry_ready_o (back_ready),
    .out_o         (out_o)
  );

endmodule

// ===== src/ldh_sincos.sv =====
// ----------------------------------------------------------------------------
// ldh_sincos
// Iterative sine/cosine lane: CORDIC rotation, gain removal by square root
// and two restoring dividers. Result holds until the next start.
// ----------------------------------------------------------------------------
module ldh_sincos (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ldh_pkg::ang_t z_i,
  input  logic          neg_i,
  output logic          done_o,
  output ldh_pkg::rot_t sin_o,
  output ldh_pkg::rot_t cos_o
);
  import ldh_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT,
    ST_ABS,
    ST_SQR,
    ST_SUM,
    ST_ROOT,
    ST_DIVI,
    ST_DIV,
    ST_DONE
  } state_e;

  localparam logic [CNT_W-1:0] ROT_LAST  = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic                    neg_q, neg_d;
  ang_t                    z_q, z_d;
  logic signed [XY_W-1:0]  x_q, x_d, y_q, y_d;
  logic                    xneg_q, xneg_d, yneg_q, yneg_d;
  logic [MAG_W-1:0]        ax_q, ax_d, ay_q, ay_d;
  logic [SQ_W-1:0]         xx_q, xx_d, yy_q, yy_d;
  logic [RAD_W-1:0]        rem_q, rem_d, root_q, root_d, rbit_q, rbit_d;
  logic [NUM_W-1:0]        nc_q, nc_d, ns_q, ns_d, dsh_q, dsh_d;
  logic [DIV_STEPS-1:0]    qc_q, qc_d, qs_q, qs_d;

  logic signed [XY_W-1:0]  x_sh, y_sh, xs, ys, xa, ya;
  logic [RAD_W-1:0]        trial;
  logic [RT_W-1:0]         r;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    z_d     = z_q;
    x_d     = x_q;
    y_d     = y_q;
    xneg_d  = xneg_q;
    yneg_d  = yneg_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    xx_d    = xx_q;
    yy_d    = yy_q;
    rem_d   = rem_q;
    root_d  = root_q;
    rbit_d  = rbit_q;
    nc_d    = nc_q;
    ns_d    = ns_q;
    dsh_d   = dsh_q;
    qc_d    = qc_q;
    qs_d    = qs_q;

    x_sh  = x_q >>> cnt_q;
    y_sh  = y_q >>> cnt_q;
    xs    = neg_q ? -x_q : x_q;
    ys    = neg_q ? -y_q : y_q;
    xa    = xs[XY_W-1] ? -xs : xs;
    ya    = ys[XY_W-1] ? -ys : ys;
    trial = root_q + rbit_q;
    r     = root_q[RT_W-1:0];
    if (r == '0) begin
      r = RT_W'(1);
    end

    case (state_q)
      ST_IDLE, ST_DONE: begin
        if (start_i) begin
          z_d     = z_i;
          neg_d   = neg_i;
          x_d     = XY_W'(64'sd1073741824);
          y_d     = '0;
          cnt_d   = '0;
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        // Rotate toward zero residual angle.
        if (!z_q[31]) begin
          x_d = x_q - y_sh;
          y_d = y_q + x_sh;
          z_d = z_q - atan_q28(ATAN_IDX_W'(cnt_q));
        end else begin
          x_d = x_q + y_sh;
          y_d = y_q - x_sh;
          z_d = z_q + atan_q28(ATAN_IDX_W'(cnt_q));
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ROT_LAST) begin
          state_d = ST_ABS;
        end
      end
      ST_ABS: begin
        xneg_d  = xs[XY_W-1];
        yneg_d  = ys[XY_W-1];
        ax_d    = xa[MAG_W-1:0];
        ay_d    = ya[MAG_W-1:0];
        state_d = ST_SQR;
      end
      ST_SQR: begin
        xx_d    = ax_q * ax_q;
        yy_d    = ay_q * ay_q;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        rem_d   = RAD_W'(xx_q) + RAD_W'(yy_q);
        root_d  = '0;
        rbit_d  = RAD_W'(1) << (RAD_W - 2);
        cnt_d   = '0;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          root_d = (root_q >> 1) + rbit_q;
        end else begin
          root_d = root_q >> 1;
        end
        rbit_d = rbit_q >> 2;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == ROOT_LAST) begin
          state_d = ST_DIVI;
        end
      end
      ST_DIVI: begin
        // Bias numerators by half the divisor for round-to-nearest.
        nc_d    = (NUM_W'(ax_q) << 14) + NUM_W'(r >> 1);
        ns_d    = (NUM_W'(ay_q) << 14) + NUM_W'(r >> 1);
        dsh_d   = NUM_W'(r) << (DIV_STEPS - 1);
        qc_d    = '0;
        qs_d    = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (nc_q >= dsh_q) begin
          nc_d = nc_q - dsh_q;
          qc_d = {qc_q[DIV_STEPS-2:0], 1'b1};
        end else begin
          qc_d = {qc_q[DIV_STEPS-2:0], 1'b0};
        end
        if (ns_q >= dsh_q) begin
          ns_d = ns_q - dsh_q;
          qs_d = {qs_q[DIV_STEPS-2:0], 1'b1};
        end else begin
          qs_d = {qs_q[DIV_STEPS-2:0], 1'b0};
        end
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = ST_DONE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    z_q    <= z_d;
    x_q    <= x_d;
    y_q    <= y_d;
    xneg_q <= xneg_d;
    yneg_q <= yneg_d;
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    xx_q   <= xx_d;
    yy_q   <= yy_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    rbit_q <= rbit_d;
    nc_q   <= nc_d;
    ns_q   <= ns_d;
    dsh_q  <= dsh_d;
    qc_q   <= qc_d;
    qs_q   <= qs_d;
  end

  assign done_o = (state_q == ST_DONE);
  assign cos_o  = xneg_q ? -$signed({1'b0, qc_q}) : $signed({1'b0, qc_q});
  assign sin_o  = yneg_q ? -$signed({1'b0, qs_q}) : $signed({1'b0, qs_q});

endmodule

// ===== src/ldh_front.sv =====
// ----------------------------------------------------------------------------
// ldh_front
// Accepts link parameter words and folds both angles into +-pi/2,
// marking those whose sine and cosine must be negated.
// ----------------------------------------------------------------------------
module ldh_front (
  ldh_in_if.sink         in_i,
  output ldh_pkg::work_t entry_o,
  output logic           entry_valid_o,
  input  logic           entry_ready_i
);
  import ldh_pkg::*;

  function automatic ang_t widen(input ang_in_t ang);
    return {ang[15], ang, 15'd0};
  endfunction

  ang_t za, zt;

  always_comb begin
    za = widen(in_i.twist_angle);
    zt = widen(in_i.joint_angle);

    entry_o.link_length = in_i.link_length;
    entry_o.link_offset = in_i.link_offset;

    if (za > HALF_PI_Q28) begin
      entry_o.z_alpha   = za - PI_Q28;
      entry_o.neg_alpha = 1'b1;
    end else if (za < -HALF_PI_Q28) begin
      entry_o.z_alpha   = za + PI_Q28;
      entry_o.neg_alpha = 1'b1;
    end else begin
      entry_o.z_alpha   = za;
      entry_o.neg_alpha = 1'b0;
    end

    if (zt > HALF_PI_Q28) begin
      entry_o.z_theta   = zt - PI_Q28;
      entry_o.neg_theta = 1'b1;
    end else if (zt < -HALF_PI_Q28) begin
      entry_o.z_theta   = zt + PI_Q28;
      entry_o.neg_theta = 1'b1;
    end else begin
      entry_o.z_theta   = zt;
      entry_o.neg_theta = 1'b0;
    end
  end

  assign entry_valid_o = in_i.valid;
  assign in_i.ready    = entry_ready_i;

endmodule

// ===== src/ldh_queue.sv =====
// ----------------------------------------------------------------------------
// ldh_queue
// Short FIFO of reduced work items between the front and the back.
// ----------------------------------------------------------------------------
module ldh_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ldh_pkg::work_t push_data_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output ldh_pkg::work_t pop_data_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);
  import ldh_pkg::*;

  work_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/ldh_back.sv =====
// ----------------------------------------------------------------------------
// ldh_back
// Runs both sine/cosine lanes, forms the matrix products and emits the
// four rows of the link transform through an output register.
// ----------------------------------------------------------------------------
module ldh_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ldh_pkg::work_t entry_i,
  input  logic           entry_valid_i,
  output logic           entry_ready_o,
  ldh_out_if.source      out_o
);
  import ldh_pkg::*;

  typedef enum logic {
    ENG_IDLE,
    ENG_RUN
  } eng_e;

  typedef struct packed {
    rot_t                sa;
    rot_t                ca;
    rot_t                st;
    rot_t                ct;
    len_t                a;
    logic signed [31:0]  p_cs;
    logic signed [31:0]  p_cc;
    logic signed [31:0]  p_ss;
    logic signed [31:0]  p_sc;
    logic signed [39:0]  p_ds;
    logic signed [39:0]  p_dc;
  } mat_t;

  function automatic logic signed [25:0] rnd14(input logic signed [39:0] p);
    logic signed [39:0] s;
    s = p + 40'sd8192;
    return s[39:14];
  endfunction

  function automatic len_t sat24(input logic signed [26:0] v);
    len_t res;
    if (v > 27'(LEN_MAX)) begin
      res = LEN_MAX;
    end else if (v < 27'(LEN_MIN)) begin
      res = LEN_MIN;
    end else begin
      res = v[23:0];
    end
    return res;
  endfunction

  eng_e eng_q, eng_d;
  len_t a_q, d_q;

  logic start, done_a, done_t;
  rot_t sa, ca, st, ct;

  mat_t mat_q, mat_d;
  logic mat_vld_q, mat_vld_d, mat_ld, mat_free;
  row_e row_q, row_d;
  logic emit_ld, emit_last;

  logic       out_vld_q, out_vld_d;
  logic [1:0] out_row_q, out_row_d;
  rot_t       out_c0_q, out_c0_d, out_c1_q, out_c1_d, out_c2_q, out_c2_d;
  len_t       out_c3_q, out_c3_d;
  logic       out_last_q, out_last_d;

  logic signed [25:0] r_ds, r_dc;

  ldh_sincos u_alpha (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .z_i     (entry_i.z_alpha),
    .neg_i   (entry_i.neg_alpha),
    .done_o  (done_a),
    .sin_o   (sa),
    .cos_o   (ca)
  );

  ldh_sincos u_theta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .z_i     (entry_i.z_theta),
    .neg_i   (entry_i.neg_theta),
    .done_o  (done_t),
    .sin_o   (st),
    .cos_o   (ct)
  );

  assign entry_ready_o = (eng_q == ENG_IDLE);
  assign start         = entry_ready_o && entry_valid_i;

  assign emit_ld   = mat_vld_q && (!out_vld_q || out_o.ready);
  assign emit_last = emit_ld && (row_q == ROW_3);
  assign mat_free  = !mat_vld_q || emit_last;
  assign mat_ld    = (eng_q == ENG_RUN) && done_a && done_t && mat_free;

  always_comb begin
    eng_d = eng_q;
    case (eng_q)
      ENG_IDLE: begin
        if (start) begin
          eng_d = ENG_RUN;
        end
      end
      ENG_RUN: begin
        // Hold the lane results until the matrix register frees up.
        if (mat_ld) begin
          eng_d = ENG_IDLE;
        end
      end
      default: begin
        eng_d = ENG_IDLE;
      end
    endcase
  end

  always_comb begin
    mat_d      = mat_q;
    mat_d.sa   = sa;
    mat_d.ca   = ca;
    mat_d.st   = st;
    mat_d.ct   = ct;
    mat_d.a    = a_q;
    mat_d.p_cs = ca * st;
    mat_d.p_cc = ca * ct;
    mat_d.p_ss = sa * st;
    mat_d.p_sc = sa * ct;
    mat_d.p_ds = d_q * sa;
    mat_d.p_dc = d_q * ca;

    if (mat_ld) begin
      mat_vld_d = 1'b1;
    end else if (emit_last) begin
      mat_vld_d = 1'b0;
    end else begin
      mat_vld_d = mat_vld_q;
    end
  end

  always_comb begin
    r_ds = rnd14(mat_q.p_ds);
    r_dc = rnd14(mat_q.p_dc);

    row_d      = emit_ld ? row_e'(row_q + 1'b1) : row_q;
    out_row_d  = row_q;
    out_c0_d   = '0;
    out_c1_d   = '0;
    out_c2_d   = '0;
    out_c3_d   = ONE_Q14_LEN;
    out_last_d = 1'b0;
    case (row_q)
      ROW_0: begin
        out_c0_d = mat_q.ct;
        out_c1_d = -mat_q.st;
        out_c3_d = mat_q.a;
      end
      ROW_1: begin
        out_c0_d = rot_t'(rnd14(40'(mat_q.p_cs)));
        out_c1_d = rot_t'(rnd14(40'(mat_q.p_cc)));
        out_c2_d = -mat_q.sa;
        out_c3_d = sat24(-{r_ds[25], r_ds});
      end
      ROW_2: begin
        out_c0_d = rot_t'(rnd14(40'(mat_q.p_ss)));
        out_c1_d = rot_t'(rnd14(40'(mat_q.p_sc)));
        out_c2_d = mat_q.ca;
        out_c3_d = sat24({r_dc[25], r_dc});
      end
      default: begin
        out_last_d = 1'b1;
      end
    endcase

    if (emit_ld) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_q     <= ENG_IDLE;
      mat_vld_q <= 1'b0;
      row_q     <= ROW_0;
      out_vld_q <= 1'b0;
    end else begin
      eng_q     <= eng_d;
      mat_vld_q <= mat_vld_d;
      row_q     <= row_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      a_q <= entry_i.link_length;
      d_q <= entry_i.link_offset;
    end
    if (mat_ld) begin
      mat_q <= mat_d;
    end
    if (emit_ld) begin
      out_row_q  <= out_row_d;
      out_c0_q   <= out_c0_d;
      out_c1_q   <= out_c1_d;
      out_c2_q   <= out_c2_d;
      out_c3_q   <= out_c3_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.row_index = out_row_q;
  assign out_o.col_zero  = out_c0_q;
  assign out_o.col_one   = out_c1_q;
  assign out_o.col_two   = out_c2_q;
  assign out_o.col_three = out_c3_q;
  assign out_o.last_row  = out_last_q;

endmodule

// ===== src/ldh_checker.sv =====
// ----------------------------------------------------------------------------
// ldh_checker
// Port-level checks of the link transform row stream.
// ----------------------------------------------------------------------------
`include "modified_dh_link_transform_defines.svh"

module ldh_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input logic [1:0]    out_row_index_i,
  input ldh_pkg::rot_t out_col_zero_i,
  input ldh_pkg::rot_t out_col_two_i,
  input ldh_pkg::len_t out_col_three_i,
  input logic          out_last_row_i
);
  import ldh_pkg::*;

  logic [1:0] exp_row_q;

  // Advance the expected row on every taken word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_row_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      exp_row_q <= exp_row_q + 1'b1;
    end
  end

  `LDH_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_row_index_i) && $stable(out_col_three_i),
    "stalled row word changed")
  `LDH_ASSERT(a_row_order, out_valid_i, out_row_index_i == exp_row_q,
    "rows out of order")
  `LDH_ASSERT(a_last_flag, out_valid_i, out_last_row_i == (out_row_index_i == ROW_3),
    "last_row does not match row 3")
  `LDH_ASSERT(a_row3_const, out_valid_i && out_last_row_i,
    out_col_zero_i == '0 && out_col_two_i == '0 && out_col_three_i == ONE_Q14_LEN,
    "closing row is not 0 0 0 1")

endmodule

bind modified_dh_link_transform ldh_checker u_ldh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_row_index_i (out_o.row_index),
  .out_col_zero_i  (out_o.col_zero),
  .out_col_two_i   (out_o.col_two),
  .out_col_three_i (out_o.col_three),
  .out_last_row_i  (out_o.last_row)
);
